>>> rtl/core/spmu_pkg.sv
// Shared constants and types for the shuffled Park-Miller uniform generator.
`default_nettype none

package spmu_pkg;

   localparam int TABLE_SIZE = 32;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int WARMUP     = TABLE_SIZE + 8;
   localparam int CNT_W      = $clog2(WARMUP);

   localparam int SAMPLE_W   = 31;
   localparam int SEED_W     = 32;
   localparam int MULT_W     = 15;
   localparam int PROD_W     = SEED_W + MULT_W;

   localparam logic [MULT_W-1:0]   MULT_A        = MULT_W'(16807);
   localparam logic [SAMPLE_W-1:0] MODULUS       = 31'h7FFF_FFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_CAP    = SAMPLE_W'(2147483389);
   localparam logic [SAMPLE_W-1:0] TABLE_DIVISOR =
      SAMPLE_W'(1 + (2147483646 / TABLE_SIZE));

   // operand handoff into the shared multiply-reduce unit
   typedef struct packed {
      logic              load;
      logic [SEED_W-1:0] operand;
   } mul_ctl_type;

endpackage

`default_nettype wire

>>> rtl/core/shuffled_park_miller_uniform_core.sv
// Top level: sequencer, state registers and output stage of the uniform generator.
//
//  channel   dir   handshake                 payload
//  req_*     in    req_tvalid/req_tready     req_tdata[0] = request
//  rsp_*     out   rsp_tvalid/rsp_tready     rsp_tdata[30:0] = sample
//  csr_*     in    csr_wen                   csr_wdata = seed_value (signed)
//
// A sample multiplies in the accept cycle with the table read issued; reduce and
// table update follow once the output register is free. A request word with
// request clear is accepted without starting a sample. The first request after
// reset or a seed write first runs 40 warm-up steps. Reset is synchronous; no
// clearing pass is needed.
// A waiting result does not block acceptance; the update cycle holds until the
// output register is free.
`default_nettype none

module shuffled_park_miller_uniform_core
   import spmu_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [7:0]               req_tdata,   // [0] request
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [31:0]              rsp_tdata,   // [30:0] sample
   input  wire logic                     csr_wen,
   input  wire logic signed [SEED_W-1:0] csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_INIT_MUL = 5'b00010,
      ST_INIT_RED = 5'b00100,
      ST_MUL      = 5'b01000,
      ST_RED      = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [SEED_W-1:0]    gen_ff, gen_in;
   logic [SAMPLE_W-1:0]  prev_ff, prev_in;
   logic [SEED_W-1:0]    seed_ff, seed_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]  rsp_data_ff, rsp_data_in;

   mul_ctl_type          mul_ctl;
   logic [SAMPLE_W-1:0]  mul_result;
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [SAMPLE_W-1:0]  ram_wr_data;
   logic                 ram_rd_en;
   logic [SAMPLE_W-1:0]  ram_rd_data;

   logic [SAMPLE_W-1:0]  quot;
   logic [IDX_W-1:0]     pick_idx;
   logic [SEED_W-1:0]    seed_start;
   logic                 accept;
   logic                 out_free;

   spmu_mulmod u_mulmod (
      .clock  (clock),
      .ctl    (mul_ctl),
      .result (mul_result)
   );

   spmu_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (pick_idx),
      .rd_data (ram_rd_data)
   );

   // table index from the previous pick, clamped to the last entry
   always_comb begin
      quot = prev_ff / TABLE_DIVISOR;
      if (quot >= SAMPLE_W'(TABLE_SIZE)) begin
         pick_idx = IDX_W'(TABLE_SIZE - 1);
      end else begin
         pick_idx = quot[IDX_W-1:0];
      end
   end

   // negate a negative seed, otherwise start from one
   assign seed_start = seed_ff[SEED_W-1] ? (~seed_ff + SEED_W'(1)) : SEED_W'(1);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in        = state_ff;
      gen_in          = gen_ff;
      prev_in         = prev_ff;
      seed_in         = seed_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      mul_ctl.load    = 1'b0;
      mul_ctl.operand = gen_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = pick_idx;
      ram_wr_data     = mul_result;
      ram_rd_en       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tdata[0]) begin
               if (prev_ff == '0) begin
                  gen_in   = seed_start;
                  cnt_in   = CNT_W'(WARMUP - 1);
                  state_in = ST_INIT_MUL;
               end else begin
                  mul_ctl.load = 1'b1;
                  ram_rd_en    = 1'b1;
                  state_in     = ST_RED;
               end
            end
         end
         ST_INIT_MUL: begin
            mul_ctl.load = 1'b1;
            state_in     = ST_INIT_RED;
         end
         ST_INIT_RED: begin
            gen_in = {1'b0, mul_result};
            // last TABLE_SIZE warm-up values fill the table top down
            if (cnt_ff < CNT_W'(TABLE_SIZE)) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = cnt_ff[IDX_W-1:0];
            end
            if (cnt_ff == '0) begin
               prev_in  = mul_result;
               state_in = ST_MUL;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = ST_INIT_MUL;
            end
         end
         ST_MUL: begin
            mul_ctl.load = 1'b1;
            ram_rd_en    = 1'b1;
            state_in     = ST_RED;
         end
         ST_RED: begin
            // hold until the output register can take the word
            if (out_free) begin
               gen_in       = {1'b0, mul_result};
               ram_wr_en    = 1'b1;
               prev_in      = ram_rd_data;
               rsp_valid_in = 1'b1;
               rsp_data_in  = (ram_rd_data > SAMPLE_CAP) ? SAMPLE_CAP : ram_rd_data;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wen) begin
         seed_in = csr_wdata;
         prev_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= '0;
         prev_ff      <= '0;
         seed_ff      <= '1;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         prev_ff      <= prev_in;
         seed_ff      <= seed_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   a_red_commits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RED) && !rsp_valid_ff |=> rsp_tvalid && (state_ff == ST_IDLE))
      else $error("update cycle with a free output did not deliver a word");

   a_idle_word_keeps_state: assert property (@(posedge clock) disable iff (reset)
      accept && !req_tdata[0] && !csr_wen |=> $stable(prev_ff) && $stable(gen_ff)
         && (state_ff == ST_IDLE))
      else $error("word with request clear changed generator state");

   a_warmup_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT_RED) && (cnt_ff == '0) |=> (state_ff == ST_MUL)
         && (prev_ff == gen_ff[SAMPLE_W-1:0]))
      else $error("warm-up did not hand its last value to the first pick");

   a_gen_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !gen_ff[SEED_W-1])
      else $error("generator state left 31-bit range while idle");

   a_sample_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff <= SAMPLE_CAP))
      else $error("sample above cap");

endmodule

`default_nettype wire

>>> rtl/core/spmu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module spmu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/spmu_mulmod.sv
// Shared multiply-by-16807 and reduce-mod-(2^31-1) unit, product registered.
`default_nettype none

module spmu_mulmod
   import spmu_pkg::*;
(
   input  wire logic                clock,
   input  wire mul_ctl_type         ctl,
   output logic      [SAMPLE_W-1:0] result
);

   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   prod_in;
   logic [SAMPLE_W:0]   fold;
   logic [SAMPLE_W:0]   fold_sub;

   assign prod_in = PROD_W'(ctl.operand) * PROD_W'(MULT_A);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         prod_ff <= prod_in;
      end
   end

   // 2^31 == 1 mod M: fold high bits onto low bits, one correction suffices
   always_comb begin
      fold     = {1'b0, prod_ff[SAMPLE_W-1:0]}
               + (SAMPLE_W+1)'(prod_ff[PROD_W-1:SAMPLE_W]);
      fold_sub = fold - {1'b0, MODULUS};
      if (fold >= {1'b0, MODULUS}) begin
         result = fold_sub[SAMPLE_W-1:0];
      end else begin
         result = fold[SAMPLE_W-1:0];
      end
   end

endmodule

`default_nettype wire

>>> dv/shuffled_park_miller_uniform_core_tb.sv
// Testbench for the shuffled Park-Miller uniform generator: stream stimulus and checking.
`timescale 1ns / 100ps

class sample_predictor;
   localparam int          SLOTS    = spmu_pkg::TABLE_SIZE;
   localparam bit [63:0]   MULT     = 64'd16807;
   localparam bit [63:0]   PRIME    = 64'd2147483647;
   localparam bit [30:0]   CAP      = 31'd2147483389;
   localparam int unsigned PICK_DIV = 1 + 2147483646 / SLOTS;

   bit [31:0] seed;
   bit [30:0] gen_state;
   bit [30:0] shuffle_mem [SLOTS];
   bit [30:0] prev_pick;
   bit [30:0] pending_samples [$];
   int        failures;

   function new();
      seed      = 32'hFFFF_FFFF;
      gen_state = '0;
      prev_pick = '0;
      failures  = 0;
      foreach (shuffle_mem[i]) shuffle_mem[i] = '0;
   endfunction

   function bit [30:0] mul_mod(bit [63:0] s);
      return 31'((s * MULT) % PRIME);
   endfunction

   function void load_seed(bit [31:0] value);
      seed      = value;
      prev_pick = '0;
      foreach (shuffle_mem[i]) shuffle_mem[i] = '0;
   endfunction

   // warm up the generator and fill the table from the top slot down
   function void reload();
      bit [63:0] s;
      if (seed[31]) s = {32'd0, (~seed + 32'd1)};
      else s = 64'd1;
      for (int n = SLOTS + 7; n >= 0; n--) begin
         s = {33'd0, mul_mod(s)};
         if (n < SLOTS) shuffle_mem[n] = s[30:0];
      end
      gen_state = s[30:0];
      prev_pick = shuffle_mem[0];
   endfunction

   function void note_word(logic [7:0] word);
      int unsigned idx;
      bit [30:0]   pick;
      if (word[0] !== 1'b1) return;
      if (prev_pick == 0) reload();
      gen_state = mul_mod({33'd0, gen_state});
      idx = prev_pick / PICK_DIV;
      if (idx >= SLOTS) idx = SLOTS - 1;
      prev_pick        = shuffle_mem[idx];
      shuffle_mem[idx] = gen_state;
      pick = (prev_pick > CAP) ? CAP : prev_pick;
      pending_samples.push_back(pick);
   endfunction

   function void check_word(logic [31:0] word);
      bit [30:0] want;
      if (pending_samples.size() == 0) begin
         $error("sample %0d arrived with nothing pending", word[30:0]);
         failures++;
         return;
      end
      want = pending_samples.pop_front();
      if (word[30:0] !== want) begin
         $error("sample mismatch: expected %0d, actual %0d", want, word[30:0]);
         failures++;
      end
   endfunction
endclass

module shuffled_park_miller_uniform_core_tb;
   import spmu_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 100;
   localparam int SEGMENTS    = 6;

   localparam logic [7:0] WORD_REQ  = 8'h01;
   localparam logic [7:0] WORD_IDLE = 8'h00;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [31:0]              rsp_tdata;
   logic                     csr_wen    = 1'b0;
   logic signed [SEED_W-1:0] csr_wdata  = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int calm_left     = 0;
   int cycle_count   = 0;

   sample_predictor sb = new();

   logic [31:0] edge_seeds [7] = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFE,
                                   32'h8000_0002, 32'h8000_0000, 32'h8000_0001,
                                   32'h7FFF_FFFF};

   shuffled_park_miller_uniform_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) sb.note_word(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= ((calm_left > 0) ? 0 : recv_idle_pct));
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_word(input logic [7:0] word);
      while ($urandom_range(99) < ((calm_left > 0) ? 0 : send_idle_pct)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drop valid, let every pending sample drain, then hold off for the settle time
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      sb.load_seed(value);
      csr_wen   <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int          target;
      int          sent;
      logic [31:0] seed;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset seed, an idle word, then each extreme seed
      send_idle_pct = 37;
      recv_idle_pct = 72;
      send_word(WORD_REQ);
      send_word(WORD_IDLE);
      send_word(WORD_REQ);
      send_word(WORD_REQ);
      send_word(WORD_REQ);
      foreach (edge_seeds[i]) begin
         drain();
         write_seed(edge_seeds[i]);
         send_word(WORD_REQ);
         send_word(WORD_REQ);
         send_word((i == 3) ? WORD_IDLE : WORD_REQ);
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 2) begin
            send_idle_pct = 37;
            recv_idle_pct = 72;
         end else if (seg < 4) begin
            send_idle_pct = 72;
            recv_idle_pct = 37;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain();
         seed = ($urandom_range(7) == 0) ? edge_seeds[$urandom_range(6)] : $urandom;
         write_seed(seed);
         target = $urandom_range(68, 90);
         sent   = 0;
         while (sent < target) begin
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(19) == 0) calm_left = $urandom_range(8, 24);
            if ($urandom_range(9) == 0) begin
               send_word(WORD_IDLE);
            end else begin
               send_word(WORD_REQ);
               sent++;
            end
         end
         calm_left = 0;
      end

      drain();
      if (sb.failures == 0 && sb.pending_samples.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
